FILE: sv/brlr_pkg.sv
// Shared constants and controller/datapath interface types for the bounded random core.
package brlr_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned DIV_W  = DATA_W + 1;
    localparam int unsigned CNT_W  = 6;

    localparam logic [DATA_W-1:0] SEED_RESET = 32'd12345678;
    localparam logic [DATA_W-1:0] LCG_MUL    = 32'd1664525;
    localparam logic [DATA_W-1:0] LCG_INC    = 32'd1013904223;
    localparam logic [DIV_W-1:0]  TWO_POW_32 = 33'h1_0000_0000;
    localparam logic [CNT_W-1:0]  DIV_STEPS  = 6'd33;

    typedef struct packed {
        logic load_in;
        logic start_bkt;
        logic div_step;
        logic save_bkt;
        logic adv_seed;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic bound_zero;
        logic div_done;
        logic draw_ok;
    } t_sts;

endpackage

FILE: sv/bounded_random_lcg_reject_core.sv
// Bucket and draw divisions share one restoring divider, one quotient bit per cycle (33).
// A zero bound returns its flagged word without any division and leaves the seed alone.
// A new request is taken only after the previous one has been loaded into the output word.
// Synchronous active-low reset empties the output and loads the seed with 12345678.
// Top level of the bounded random generator with rejection sampling.
module bounded_random_lcg_reject_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [brlr_pkg::DATA_W-1:0] i_bound,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [brlr_pkg::DATA_W-1:0] o_value,
    output logic                        o_bad_bound
);

    brlr_pkg::t_cmd cmd;
    brlr_pkg::t_sts sts;

    // sequence the request
    brlr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // compute bucket, draws and result word
    brlr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_bound     (i_bound),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_value     (o_value),
        .o_bad_bound (o_bad_bound)
    );

endmodule

FILE: sv/brlr_ctrl.sv
// Controller state machine sequencing bucket division, seed advance and draw rejection.
module brlr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    input  brlr_pkg::t_sts i_sts,
    output brlr_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_BKT  = 3'd2;
    localparam logic [2:0] S_ADV  = 3'd3;
    localparam logic [2:0] S_DRAW = 3'd4;
    localparam logic [2:0] S_CHK  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       slot_free;

    // output slot may be refilled when empty or being taken this cycle
    assign slot_free = !r_out_valid || !i_stall;

    // decode state into datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_LOAD;
                end
            end
            S_LOAD: begin
                if (i_sts.bound_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.start_bkt = 1'b1;
                    n_state         = S_BKT;
                end
            end
            S_BKT: begin
                if (i_sts.div_done) begin
                    o_cmd.save_bkt = 1'b1;
                    n_state        = S_ADV;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_ADV: begin
                o_cmd.adv_seed = 1'b1;
                n_state        = S_DRAW;
            end
            S_DRAW: begin
                if (i_sts.div_done) begin
                    n_state = S_CHK;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_CHK: begin
                // reject draws at or above the bound
                n_state = i_sts.draw_ok ? S_DONE : S_ADV;
            end
            S_DONE: begin
                if (slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // track the output word
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

FILE: sv/brlr_dp.sv
// Datapath: seed register, LCG update, shared serial divider and output word register.
module brlr_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [brlr_pkg::DATA_W-1:0]   i_bound,
    input  brlr_pkg::t_cmd                i_cmd,
    output brlr_pkg::t_sts                o_sts,
    output logic [brlr_pkg::DATA_W-1:0]   o_value,
    output logic                          o_bad_bound
);

    logic [brlr_pkg::DATA_W-1:0] r_bound;
    logic [brlr_pkg::DATA_W-1:0] r_seed;
    logic [brlr_pkg::DATA_W-1:0] n_seed;
    logic [brlr_pkg::DIV_W-1:0]  r_bucket;
    logic [brlr_pkg::DIV_W-1:0]  r_divisor;
    logic [brlr_pkg::DIV_W-1:0]  r_rem;
    logic [brlr_pkg::DIV_W-1:0]  r_quo;
    logic [brlr_pkg::CNT_W-1:0]  r_cnt;
    logic [brlr_pkg::DATA_W-1:0] r_value;
    logic                        r_bad;
    logic [brlr_pkg::DIV_W:0]    rem_sh;
    logic [brlr_pkg::DIV_W:0]    diff;
    logic                        ge;
    logic [brlr_pkg::DATA_W-1:0] prod;

    // next seed: multiply and add, modulo 2^32
    assign prod   = r_seed * brlr_pkg::LCG_MUL;
    assign n_seed = prod + brlr_pkg::LCG_INC;

    // one restoring division step
    assign rem_sh = {r_rem, r_quo[brlr_pkg::DIV_W-1]};
    assign diff   = rem_sh - {1'b0, r_divisor};
    assign ge     = !diff[brlr_pkg::DIV_W];

    // hold the seed across requests, advance once per draw
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= brlr_pkg::SEED_RESET;
            r_cnt  <= '0;
        end else begin
            if (i_cmd.adv_seed) begin
                r_seed <= n_seed;
            end
            if (i_cmd.start_bkt || i_cmd.adv_seed) begin
                r_cnt <= brlr_pkg::DIV_STEPS;
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // capture the word, run the divider, register the result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_bound <= i_bound;
        end
        if (i_cmd.save_bkt) begin
            r_bucket <= r_quo;
        end
        if (i_cmd.start_bkt) begin
            r_divisor <= {1'b0, r_bound};
            r_rem     <= '0;
            r_quo     <= brlr_pkg::TWO_POW_32;
        end else if (i_cmd.adv_seed) begin
            r_divisor <= r_bucket;
            r_rem     <= '0;
            r_quo     <= {1'b0, n_seed};
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? diff[brlr_pkg::DIV_W-1:0] : rem_sh[brlr_pkg::DIV_W-1:0];
            r_quo <= {r_quo[brlr_pkg::DIV_W-2:0], ge};
        end
        if (i_cmd.load_out) begin
            r_bad   <= (r_bound == '0);
            r_value <= (r_bound == '0) ? '0 : r_quo[brlr_pkg::DATA_W-1:0];
        end
    end

    assign o_sts.bound_zero = (r_bound == '0);
    assign o_sts.div_done   = (r_cnt == '0);
    assign o_sts.draw_ok    = (r_quo < {1'b0, r_bound});
    assign o_value          = r_value;
    assign o_bad_bound      = r_bad;

endmodule

FILE: tb/bounded_random_lcg_reject_core_tb.sv
// Self-checking bench for the bounded random core: LCG draw prediction, random bursts and stalls.
`timescale 1ns / 100ps

module bounded_random_lcg_reject_core_tb;

    typedef logic [brlr_pkg::DATA_W-1:0] t_word;

    // Generator constants
    localparam t_word     SEED_INIT  = 32'd12345678;
    localparam t_word     SEED_MUL   = 32'd1664525;
    localparam t_word     SEED_INC   = 32'd1013904223;
    localparam bit [32:0] RANGE_FULL = 33'h1_0000_0000;

    localparam int RST_CYCLES    = 8;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int HOLDOFF_AT    = 250;
    localparam int HOLDOFF_LEN   = 600;
    localparam int TAIL_CYCLES   = 200;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int MAX_REPORTED  = 10;

    typedef struct {
        t_word bound;
        bit    wait_drain;
    } t_bound_req;

    typedef struct {
        t_word value;
        logic  bad_bound;
    } t_draw;

    typedef enum int {
        RX_FREE,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } t_rx_mode;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    t_word i_bound = '0;
    logic  i_stall = 1'b0;
    logic  o_stall;
    logic  o_valid;
    t_word o_value;
    logic  o_bad_bound;

    t_bound_req bound_q[$];
    t_draw      pending_draws[$];
    t_word      model_seed = SEED_INIT;
    int         accepted_cnt = 0;
    int         miss_cnt = 0;
    int         cycle_cnt = 0;

    bounded_random_lcg_reject_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_bound     (i_bound),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_value     (o_value),
        .o_bad_bound (o_bad_bound)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Advance the seed until the quotient lands below the bound
    function automatic t_draw draw_bounded(t_word limit);
        bit [32:0] bucket;
        bit [32:0] quot;
        t_draw     res;
        res.value     = '0;
        res.bad_bound = 1'b1;
        if (limit == '0)
            return res;
        bucket = RANGE_FULL / {1'b0, limit};
        do begin
            model_seed = model_seed * SEED_MUL + SEED_INC;
            quot       = {1'b0, model_seed} / bucket;
        end while (quot >= {1'b0, limit});
        res.value     = quot[brlr_pkg::DATA_W-1:0];
        res.bad_bound = 1'b0;
        return res;
    endfunction

    function automatic void log_miss(string msg);
        miss_cnt++;
        if (miss_cnt <= MAX_REPORTED)
            $display("[%0d] mismatch: %s", cycle_cnt, msg);
    endfunction

    function automatic void queue_bound(t_word bound, bit wait_drain);
        t_bound_req req;
        req.bound      = bound;
        req.wait_drain = wait_drain;
        bound_q.push_back(req);
    endfunction

    // Random bound: mostly random widths, some zeros, ones and high bounds
    function automatic t_word pick_bound();
        int    sel;
        int    width;
        t_word mask;
        sel = $urandom_range(0, 99);
        if (sel < 5)
            return '0;
        if (sel < 10)
            return t_word'(1);
        if (sel < 20)
            return $urandom;
        if (sel < 30)
            return {1'b1, 31'($urandom)};
        width = $urandom_range(1, brlr_pkg::DATA_W);
        mask  = (width == brlr_pkg::DATA_W) ? '1 : ((t_word'(1) << width) - 1);
        return $urandom & mask;
    endfunction

    // Drive request words in bursts; predict each word as it is taken
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        t_bound_req nxt;
        bit         offer;
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            i_bound    <= '0;
            model_seed  = SEED_INIT;
            burst_left  = $urandom_range(1, 40);
            gap_left    = 0;
        end else begin
            if (i_valid && !o_stall) begin
                pending_draws.push_back(draw_bounded(i_bound));
                accepted_cnt++;
            end
            // hold a stalled word, otherwise pick the next one
            if (!(i_valid && o_stall)) begin
                offer = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (bound_q.size() != 0) begin
                    if (!(bound_q[0].wait_drain && pending_draws.size() != 0)) begin
                        nxt   = bound_q.pop_front();
                        offer = 1'b1;
                    end
                end
                if (offer) begin
                    i_bound <= nxt.bound;
                    burst_left--;
                    if (burst_left <= 0) begin
                        gap_left   = $urandom_range(0, 8);
                        burst_left = $urandom_range(1, 40);
                    end
                end
                i_valid <= offer;
            end
        end
    end

    // Stall the result side on its own pattern, with one long hold-off
    t_rx_mode rx_mode      = RX_FREE;
    int       phase_left   = 0;
    int       holdoff_left = 0;
    bit       holdoff_done = 1'b0;

    always @(posedge i_clk) begin
        bit stall_now;
        stall_now = 1'b0;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (holdoff_left > 0) begin
                holdoff_left--;
                stall_now = 1'b1;
            end else if (!holdoff_done && accepted_cnt >= HOLDOFF_AT) begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_LEN - 1;
                stall_now    = 1'b1;
            end else begin
                if (phase_left == 0) begin
                    rx_mode    = t_rx_mode'($urandom_range(0, 3));
                    phase_left = $urandom_range(20, 200);
                end
                phase_left--;
                case (rx_mode)
                    RX_FREE:     stall_now = 1'b0;
                    RX_COIN:     stall_now = ($urandom_range(0, 1) == 1);
                    RX_SPARSE:   stall_now = ($urandom_range(0, 3) == 0);
                    RX_PERIODIC: stall_now = ((cycle_cnt % 5) < 2);
                    default:     stall_now = 1'b0;
                endcase
            end
            i_stall <= stall_now;
        end
    end

    // Check each taken result word against the oldest prediction
    always @(posedge i_clk) begin
        t_draw want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_draws.size() == 0) begin
                log_miss($sformatf("unexpected word value=%h bad_bound=%b",
                                   o_value, o_bad_bound));
            end else begin
                want = pending_draws.pop_front();
                if (o_value !== want.value)
                    log_miss($sformatf("value exp=%h got=%h", want.value, o_value));
                if (o_bad_bound !== want.bad_bound)
                    log_miss($sformatf("bad_bound exp=%b got=%b",
                                       want.bad_bound, o_bad_bound));
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        // directed: zero bound, bound of one, high bounds, field extremes
        queue_bound(32'd0,          1'b0);
        queue_bound(32'd1,          1'b0);
        queue_bound(32'd2,          1'b0);
        queue_bound(32'd3,          1'b0);
        queue_bound(32'hFFFF_FFFF,  1'b0);
        queue_bound(32'hFFFF_FFFE,  1'b0);
        queue_bound(32'h8000_0000,  1'b0);
        queue_bound(32'h8000_0001,  1'b0);
        queue_bound(32'h7FFF_FFFF,  1'b0);
        queue_bound(32'd0,          1'b0);
        queue_bound(32'd0,          1'b0);
        queue_bound(32'h5555_5555,  1'b0);
        queue_bound(32'hAAAA_AAAA,  1'b0);
        queue_bound(32'd1,          1'b0);
        queue_bound(32'd1,          1'b0);
        queue_bound(32'h4000_0001,  1'b0);
        queue_bound(32'h5555_5556,  1'b0);
        queue_bound(32'd5,          1'b0);
        queue_bound(32'd10,         1'b0);
        queue_bound(32'hC000_0000,  1'b0);
        queue_bound(32'd0,          1'b0);
        // random part, with a full drain before it and at two points inside
        for (int n = 0; n < RANDOM_ITEMS; n++)
            queue_bound(pick_bound(), (n == 0) || (n == 400) || (n == 750));

        i_rst_n = 1'b0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (bound_q.size() != 0 || i_valid)
            @(posedge i_clk);
        while (pending_draws.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (pending_draws.size() != 0)
            log_miss($sformatf("%0d words never arrived", pending_draws.size()));
        if (miss_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/brlr_pkg.sv
sv/brlr_ctrl.sv
sv/brlr_dp.sv
sv/bounded_random_lcg_reject_core.sv
tb/bounded_random_lcg_reject_core_tb.sv
